// ===== rtl/core/i2cmra_pkg.sv =====
`default_nettype none

package i2cmra_pkg;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_START_SETUP = 4'd1,
        PH_START_HOLD  = 4'd2,
        PH_TX_LOW      = 4'd3,
        PH_TX_HIGH     = 4'd4,
        PH_ACK_LOW     = 4'd5,
        PH_ACK_HIGH    = 4'd6,
        PH_RX_LOW      = 4'd7,
        PH_RX_HIGH     = 4'd8,
        PH_MACK_LOW    = 4'd9,
        PH_MACK_HIGH   = 4'd10,
        PH_RS_LOW      = 4'd11,
        PH_STOP_LOW    = 4'd12,
        PH_STOP_SETUP  = 4'd13,
        PH_STOP_END    = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        STAGE_DEVICE   = 2'd0,
        STAGE_REGISTER = 2'd1,
        STAGE_DATA     = 2'd2
    } stage_t;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] CFG_HALF_PERIOD = 8'd0;
    localparam logic [7:0] CFG_ACK_TIMEOUT = 8'd1;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd3;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    localparam int         BITS_PER_BYTE = 8;
    localparam int         IN_DATA_W     = 40;
    localparam int         OUT_DATA_W    = 16;

    typedef struct packed {
        logic       status;
        logic       done_res;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_level;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_master_register_access_core.sv =====
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   s_tuser cmd, s_tdata transaction fields and SDA
// m_*       out        m_tvalid/m_tready   m_tdata line levels and status, m_tlast
// cfg_*     in         cfg_valid/cfg_ready cfg_index register number, cfg_data value
//
// One input transfer is one bus tick; it is processed when it is accepted and its result is registered.
// The result is held in one output register, so a new tick is taken every cycle
// as long as the output register is empty or is being drained in the same cycle.
// When m_tready stays low the output register holds its result and s_tready drops.
// Reset leaves the controller idle and the output register empty; the result fields themselves are not reset.
// Configuration writes are always accepted, as cfg_ready is tied high, and are registered.
module i2c_master_register_access_core
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // cmd
    input  wire logic [1:0]                           s_tuser,
    // device_address, register_address, write_byte, read_count, sda_in, zero fill
    input  wire logic [i2cmra_pkg::IN_DATA_W-1:0]     s_tdata,

    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // scl_level, sda_pull_low, busy_res, read_valid, read_byte, done_res, status, zero fill
    output logic [i2cmra_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                      m_tlast,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [7:0]                           cfg_index,
    input  wire logic [7:0]                           cfg_data
);

    import i2cmra_pkg::*;

    logic [7:0] half_period_reg;
    logic [7:0] ack_timeout_reg;

    phase_t     phase_reg,     phase_next;
    logic [3:0] bit_cnt_reg,   bit_cnt_next;
    logic [7:0] shift_reg,     shift_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] tick_div_reg,  tick_div_next;
    logic [7:0] ack_wait_reg,  ack_wait_next;
    logic [7:0] device_reg,    device_next;
    logic [7:0] register_reg,  register_next;
    logic [7:0] data_reg,      data_next;
    logic       is_read_reg,   is_read_next;
    stage_t     stage_reg,     stage_next;
    logic       err_reg,       err_next;

    logic       out_valid_reg;
    result_t    result_reg,    result_next;
    logic       last_reg,      last_next;

    logic       accept;
    logic [1:0] cmd;
    logic       sda_in;
    logic [7:0] half_len;
    logic [7:0] td_inc;
    logic       seg_over;
    logic [7:0] td_seg;
    logic [3:0] bit_inc;
    logic [7:0] bytes_dec;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       rd_last;
    logic       done;
    logic       status;
    logic       scl_level;
    logic       sda_pull_low;
    logic       mack;

    assign cmd       = s_tuser;
    assign sda_in    = s_tdata[32];
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign half_len  = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
    assign td_inc    = tick_div_reg + 8'd1;
    assign seg_over  = (td_inc >= half_len);
    assign td_seg    = seg_over ? 8'd0 : td_inc;
    assign bit_inc   = bit_cnt_reg + 4'd1;
    assign bytes_dec = (bytes_left_reg != 8'd0) ? bytes_left_reg - 8'd1 : bytes_left_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        tick_div_next   = tick_div_reg;
        ack_wait_next   = ack_wait_reg;
        device_next     = device_reg;
        register_next   = register_reg;
        data_next       = data_reg;
        is_read_next    = is_read_reg;
        stage_next      = stage_reg;
        err_next        = err_reg;
        rd_valid        = 1'b0;
        rd_byte         = 8'd0;
        rd_last         = 1'b0;
        done            = 1'b0;
        status          = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (cmd == CMD_WRITE || cmd == CMD_READ)
                begin
                    device_next     = s_tdata[7:0];
                    register_next   = s_tdata[15:8];
                    data_next       = s_tdata[23:16];
                    bytes_left_next = (s_tdata[31:24] == 8'd0) ? 8'd1 : s_tdata[31:24];
                    is_read_next    = (cmd == CMD_READ);
                    stage_next      = STAGE_DEVICE;
                    err_next        = 1'b0;
                    tick_div_next   = 8'd0;
                    bit_cnt_next    = 4'd0;
                    ack_wait_next   = 8'd0;
                    phase_next      = PH_START_SETUP;
                end
            end
            PH_START_SETUP:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    phase_next = PH_START_HOLD;
                end
            end
            PH_START_HOLD:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    shift_next   = (stage_reg == STAGE_DATA) ? device_reg + 8'd1 : device_reg;
                    bit_cnt_next = 4'd0;
                    phase_next   = PH_TX_LOW;
                end
            end
            PH_TX_LOW:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    phase_next = PH_TX_HIGH;
                end
            end
            PH_TX_HIGH:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    if (bit_inc >= 4'(BITS_PER_BYTE))
                    begin
                        bit_cnt_next = 4'd0;
                        phase_next   = PH_ACK_LOW;
                    end
                    else
                    begin
                        bit_cnt_next = bit_inc;
                        phase_next   = PH_TX_LOW;
                    end
                end
            end
            PH_ACK_LOW:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    ack_wait_next = 8'd0;
                    phase_next    = PH_ACK_HIGH;
                end
            end
            PH_ACK_HIGH:
            begin
                if (tick_div_reg < half_len)
                begin
                    tick_div_next = td_inc;
                end
                else if (!sda_in)
                begin
                    tick_div_next = 8'd0;
                    ack_wait_next = 8'd0;
                    case (stage_reg)
                        STAGE_DEVICE:
                        begin
                            shift_next   = register_reg;
                            bit_cnt_next = 4'd0;
                            stage_next   = STAGE_REGISTER;
                            phase_next   = PH_TX_LOW;
                        end
                        STAGE_REGISTER:
                        begin
                            stage_next = STAGE_DATA;
                            if (is_read_reg)
                            begin
                                phase_next = PH_RS_LOW;
                            end
                            else
                            begin
                                shift_next   = data_reg;
                                bit_cnt_next = 4'd0;
                                phase_next   = PH_TX_LOW;
                            end
                        end
                        default:
                        begin
                            if (is_read_reg)
                            begin
                                bit_cnt_next = 4'd0;
                                phase_next   = PH_RX_LOW;
                            end
                            else
                            begin
                                phase_next = PH_STOP_LOW;
                            end
                        end
                    endcase
                end
                else if (ack_wait_reg >= ack_timeout_reg)
                begin
                    tick_div_next = 8'd0;
                    err_next      = 1'b1;
                    phase_next    = PH_STOP_LOW;
                end
                else
                begin
                    ack_wait_next = ack_wait_reg + 8'd1;
                end
            end
            PH_RX_LOW:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    phase_next = PH_RX_HIGH;
                end
            end
            PH_RX_HIGH:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    shift_next = {shift_reg[6:0], sda_in};
                    if (bit_inc >= 4'(BITS_PER_BYTE))
                    begin
                        bit_cnt_next = 4'd0;
                        rd_valid     = 1'b1;
                        rd_byte      = {shift_reg[6:0], sda_in};
                        rd_last      = (bytes_left_reg <= 8'd1);
                        phase_next   = PH_MACK_LOW;
                    end
                    else
                    begin
                        bit_cnt_next = bit_inc;
                        phase_next   = PH_RX_LOW;
                    end
                end
            end
            PH_MACK_LOW:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    phase_next = PH_MACK_HIGH;
                end
            end
            PH_MACK_HIGH:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    bytes_left_next = bytes_dec;
                    phase_next      = (bytes_dec != 8'd0) ? PH_RX_LOW : PH_STOP_LOW;
                end
            end
            PH_RS_LOW:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    phase_next = PH_START_SETUP;
                end
            end
            PH_STOP_LOW:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    phase_next = PH_STOP_SETUP;
                end
            end
            PH_STOP_SETUP:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    phase_next = PH_STOP_END;
                end
            end
            PH_STOP_END:
            begin
                tick_div_next = td_seg;
                if (seg_over)
                begin
                    done       = 1'b1;
                    status     = err_reg;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next    = PH_IDLE;
                tick_div_next = 8'd0;
            end
        endcase
    end

    // Line levels follow the phase that the tick leaves the controller in.
    assign mack = (bytes_left_next > 8'd1);

    always_comb
    begin
        case (phase_next)
            PH_START_HOLD:
            begin
                scl_level = 1'b1;
                sda_pull_low = 1'b1;
            end
            PH_TX_LOW:
            begin
                scl_level = 1'b0;
                sda_pull_low = !shift_next[7];
            end
            PH_TX_HIGH:
            begin
                scl_level = 1'b1;
                sda_pull_low = !shift_next[7];
            end
            PH_ACK_LOW, PH_RX_LOW, PH_RS_LOW:
            begin
                scl_level = 1'b0;
                sda_pull_low = 1'b0;
            end
            PH_ACK_HIGH, PH_RX_HIGH:
            begin
                scl_level = 1'b1;
                sda_pull_low = 1'b0;
            end
            PH_MACK_LOW:
            begin
                scl_level = 1'b0;
                sda_pull_low = mack;
            end
            PH_MACK_HIGH:
            begin
                scl_level = 1'b1;
                sda_pull_low = mack;
            end
            PH_STOP_LOW:
            begin
                scl_level = 1'b0;
                sda_pull_low = 1'b1;
            end
            PH_STOP_SETUP:
            begin
                scl_level = 1'b1;
                sda_pull_low = 1'b1;
            end
            default:
            begin
                scl_level = 1'b1;
                sda_pull_low = 1'b0;
            end
        endcase

        result_next.scl_level    = scl_level;
        result_next.sda_pull_low = sda_pull_low;
        result_next.busy_res     = (phase_next != PH_IDLE);
        result_next.read_valid   = rd_valid;
        result_next.read_byte    = rd_byte;
        result_next.done_res     = done;
        result_next.status       = status;
        last_next                = rd_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_HALF_PERIOD)
            begin
                half_period_reg <= cfg_data;
            end
            else if (cfg_index == CFG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            bytes_left_reg <= 8'd0;
            tick_div_reg   <= 8'd0;
            ack_wait_reg   <= 8'd0;
            device_reg     <= 8'd0;
            register_reg   <= 8'd0;
            data_reg       <= 8'd0;
            is_read_reg    <= 1'b0;
            stage_reg      <= STAGE_DEVICE;
            err_reg        <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            tick_div_reg   <= tick_div_next;
            ack_wait_reg   <= ack_wait_next;
            device_reg     <= device_next;
            register_reg   <= register_next;
            data_reg       <= data_next;
            is_read_reg    <= is_read_next;
            stage_reg      <= stage_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, result_reg};
    assign m_tlast  = last_reg;

    a_start_enters_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_IDLE && (cmd == CMD_WRITE || cmd == CMD_READ))
        |=> phase_reg == PH_START_SETUP)
        else $error("Start command did not enter start setup.");

    a_tx_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TX_HIGH || phase_reg == PH_RX_HIGH) |-> bit_cnt_reg < 4'd8)
        else $error("Bit counter out of range during a data bit.");

    a_read_then_mack: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rd_valid) |=> (phase_reg == PH_MACK_LOW && m_tvalid))
        else $error("Received byte not followed by master acknowledge.");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (phase_reg == PH_IDLE && !result_reg.busy_res))
        else $error("Finished transaction did not return to idle.");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !err_reg && err_next) |=> phase_reg == PH_STOP_LOW)
        else $error("Missing acknowledge did not start a stop.");

endmodule

`default_nettype wire
